@@ sv/scc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// Types and fixed thresholds shared by the skin color classifier modules.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW   = 3'd7;

    // fixed limits of the bright rule, the value box and the hue wrap
    localparam logic [7:0] RED_HIGH     = 8'd220;
    localparam logic [7:0] GREEN_HIGH   = 8'd210;
    localparam logic [7:0] BLUE_HIGH    = 8'd170;
    localparam logic [7:0] VALUE_HIGH   = 8'd255;
    localparam logic [7:0] HUE_WRAP_LOW = 8'd155;

    typedef struct packed {
        logic [7:0] red_low;
        logic [7:0] green_low;
        logic [7:0] blue_low;
        logic [7:0] color_gap;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] val_low;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        red_low:   8'd60,
        green_low: 8'd40,
        blue_low:  8'd20,
        color_gap: 8'd15,
        hue_high:  8'd20,
        sat_low:   8'd20,
        sat_high:  8'd154,
        val_low:   8'd50
    };

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_pixel;

endpackage
`default_nettype wire

@@ sv/skin_color_pixel_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skin_color_pixel_classifier
// Flags a pixel as skin from its RGB and HSV values and eight thresholds.
// ----------------------------------------------------------------------------
// One pixel per clock while o_in_stall is low; the pixel is registered when the
// request is accepted, one level of compare logic runs, and the flag is
// registered on the output. Input stall rises only when both stages hold
// requests and the output is stalled. The user must write thresholds through
// the config port only while no request is in flight; the block itself does
// not enforce this. Thresholds reset to the documented defaults.
module skin_color_pixel_classifier
    import scc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_blue,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_red,
    input  wire logic [7:0]            i_hue,
    input  wire logic [7:0]            i_saturation,
    input  wire logic [7:0]            i_brightness,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_is_skin
);

    t_cfg   cfg;
    t_pixel r_pix;
    logic   r_pix_valid;
    logic   r_out_valid;
    logic   r_is_skin;
    logic   is_skin;
    logic   out_adv;
    logic   in_adv;

    scc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    scc_classify u_cls (
        .i_pix     (r_pix),
        .i_cfg     (cfg),
        .o_is_skin (is_skin)
    );

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_pix_valid || out_adv;
    assign o_in_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_pix_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_pix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_pix <= '{blue: i_blue, green: i_green, red: i_red, hue: i_hue,
                       saturation: i_saturation, brightness: i_brightness};
        end
        if (out_adv && r_pix_valid) begin
            r_is_skin <= is_skin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_skin   = r_is_skin;

`ifndef ASSERT_OFF
    // input side stalls only when the whole pipe is full and blocked
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_pix_valid && r_out_valid && i_out_stall))
        else $error("input stalled while pipeline has room");

    // a classified pixel moving forward shows up as a result next cycle
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_valid && out_adv) |=> o_out_valid)
        else $error("pixel stage request lost");

    // a blocked result keeps its flag until taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_is_skin)))
        else $error("stalled result changed");

    // thresholds come out of reset at their defaults
    a_cfg_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (cfg == CFG_RESET))
        else $error("thresholds not at defaults after reset");
`endif

endmodule
`default_nettype wire

@@ sv/scc_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_cfg_regs
// Threshold register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module scc_cfg_regs
    import scc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RED_LOW:   n_cfg.red_low   = i_cfg_data;
                REG_GREEN_LOW: n_cfg.green_low = i_cfg_data;
                REG_BLUE_LOW:  n_cfg.blue_low  = i_cfg_data;
                REG_COLOR_GAP: n_cfg.color_gap = i_cfg_data;
                REG_HUE_HIGH:  n_cfg.hue_high  = i_cfg_data;
                REG_SAT_LOW:   n_cfg.sat_low   = i_cfg_data;
                REG_SAT_HIGH:  n_cfg.sat_high  = i_cfg_data;
                REG_VAL_LOW:   n_cfg.val_low   = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ sv/scc_classify.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_classify
// Compare logic: RGB daylight/bright rules and the HSV box.
// ----------------------------------------------------------------------------
module scc_classify
    import scc_pkg::*;
(
    input  wire t_pixel i_pix,
    input  wire t_cfg   i_cfg,
    output logic       o_is_skin
);

    logic [7:0] max_rgb;
    logic [7:0] min_rgb;
    logic [7:0] spread;
    logic [7:0] diff_rg;
    logic       daylight;
    logic       bright;
    logic       hue_ok;
    logic       hsv_ok;

    always_comb begin
        max_rgb = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue > max_rgb) begin
            max_rgb = i_pix.blue;
        end
        min_rgb = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue < min_rgb) begin
            min_rgb = i_pix.blue;
        end
        spread  = max_rgb - min_rgb;
        diff_rg = (i_pix.red > i_pix.green) ? (i_pix.red - i_pix.green)
                                            : (i_pix.green - i_pix.red);

        daylight = (i_pix.red > i_cfg.red_low) && (i_pix.green > i_cfg.green_low) &&
                   (i_pix.blue > i_cfg.blue_low) && (spread > i_cfg.color_gap) &&
                   (diff_rg > i_cfg.color_gap) && (i_pix.red > i_pix.green) &&
                   (i_pix.red > i_pix.blue);
        bright   = (i_pix.red > RED_HIGH) && (i_pix.green > GREEN_HIGH) &&
                   (i_pix.blue > BLUE_HIGH) && (diff_rg <= i_cfg.color_gap) &&
                   (i_pix.red > i_pix.blue) && (i_pix.green > i_pix.blue);

        // red hue wraps: low end below the limit, high end above 155
        hue_ok = (i_pix.hue < i_cfg.hue_high) || (i_pix.hue > HUE_WRAP_LOW);
        hsv_ok = hue_ok && (i_pix.saturation >= i_cfg.sat_low) &&
                 (i_pix.saturation <= i_cfg.sat_high) &&
                 (i_pix.brightness >= i_cfg.val_low) &&
                 (i_pix.brightness <= VALUE_HIGH);

        o_is_skin = (daylight || bright) && hsv_ok;
    end

endmodule
`default_nettype wire

@@ test/skin_flag_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skin_flag_monitor
// Watches the pixel and flag channels of the skin color classifier. Each
// accepted pixel is classified against a local copy of the thresholds, and
// each accepted flag is compared in order. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module skin_flag_monitor
    import scc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  t_pixel                     i_pixel,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_is_skin,
    output int                         o_flags_due,
    output int                         o_mismatch_count
);

    t_cfg thresholds = CFG_RESET;
    logic skin_flags_due [$];
    int   mismatches = 0;

    function automatic logic skin_verdict(input t_pixel p, input t_cfg c);
        logic [7:0] top, bottom, spread, rg_diff;
        logic       daylight, bright, hue_ok;
        top = (p.red > p.green) ? p.red : p.green;
        if (p.blue > top) top = p.blue;
        bottom = (p.red < p.green) ? p.red : p.green;
        if (p.blue < bottom) bottom = p.blue;
        spread  = top - bottom;
        rg_diff = (p.red > p.green) ? p.red - p.green : p.green - p.red;
        daylight = (p.red > c.red_low) && (p.green > c.green_low) &&
                   (p.blue > c.blue_low) && (spread > c.color_gap) &&
                   (rg_diff > c.color_gap) && (p.red > p.green) && (p.red > p.blue);
        bright = (p.red > RED_HIGH) && (p.green > GREEN_HIGH) && (p.blue > BLUE_HIGH) &&
                 (rg_diff <= c.color_gap) && (p.red > p.blue) && (p.green > p.blue);
        // hue wraps around red: either side of the circle counts
        hue_ok = (p.hue < c.hue_high) || (p.hue > HUE_WRAP_LOW);
        return (daylight || bright) && hue_ok &&
               (p.saturation >= c.sat_low) && (p.saturation <= c.sat_high) &&
               (p.brightness >= c.val_low) && (p.brightness <= VALUE_HIGH);
    endfunction

    always @(posedge i_clk) begin : watch
        logic want;
        if (!i_rst_n) begin
            thresholds = CFG_RESET;
            skin_flags_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RED_LOW:   thresholds.red_low   = i_cfg_data;
                    REG_GREEN_LOW: thresholds.green_low = i_cfg_data;
                    REG_BLUE_LOW:  thresholds.blue_low  = i_cfg_data;
                    REG_COLOR_GAP: thresholds.color_gap = i_cfg_data;
                    REG_HUE_HIGH:  thresholds.hue_high  = i_cfg_data;
                    REG_SAT_LOW:   thresholds.sat_low   = i_cfg_data;
                    REG_SAT_HIGH:  thresholds.sat_high  = i_cfg_data;
                    REG_VAL_LOW:   thresholds.val_low   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (skin_flags_due.size() == 0) begin
                    $error("is_skin: flag with no request pending, actual %0b", i_is_skin);
                    mismatches++;
                end else begin
                    want = skin_flags_due.pop_front();
                    if (i_is_skin !== want) begin
                        $error("is_skin mismatch: expected %0b, actual %0b", want, i_is_skin);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                skin_flags_due.push_back(skin_verdict(i_pixel, thresholds));
        end
        o_flags_due      <= skin_flags_due.size();
        o_mismatch_count <= mismatches;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the skin color classifier: directed edge pixels under the reset
// thresholds, then phases of shaped random pixels under several threshold
// sets, with random gaps and stalls on both channels. Checking is done by
// skin_flag_monitor.
// ----------------------------------------------------------------------------
module tb
    import scc_pkg::*;
;

    localparam int LONG_HOLD      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 178;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = REG_RED_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_pixel                pix_drv = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_skin;

    int   flags_due;
    int   mismatch_count;
    int   idle_cycles = 0;
    logic send_burst = 1'b0;
    logic recv_burst = 1'b0;
    logic long_hold_req = 1'b0;

    skin_color_pixel_classifier uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_blue       (pix_drv.blue),
        .i_green      (pix_drv.green),
        .i_red        (pix_drv.red),
        .i_hue        (pix_drv.hue),
        .i_saturation (pix_drv.saturation),
        .i_brightness (pix_drv.brightness),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_is_skin    (is_skin)
    );

    skin_flag_monitor monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_pixel          (pix_drv),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_is_skin        (is_skin),
        .o_flags_due      (flags_due),
        .o_mismatch_count (mismatch_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // nothing accepted on either channel for too long means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // flag sink: random hold-off before each flag, one long hold on request
    initial begin : flag_sink
        int hold;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = recv_burst ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk iff out_valid);
        end
    end

    function automatic t_pixel make_pixel(input int b, input int g, input int r,
                                          input int h, input int s, input int v);
        t_pixel p;
        p.blue       = 8'(b);
        p.green      = 8'(g);
        p.red        = 8'(r);
        p.hue        = 8'(h);
        p.saturation = 8'(s);
        p.brightness = 8'(v);
        return p;
    endfunction

    function automatic int clamp8(input int x);
        return (x < 0) ? 0 : (x > 255) ? 255 : x;
    endfunction

    // mostly pixels shaped to land near the skin region of the given thresholds
    function automatic t_pixel random_pixel(input t_cfg c);
        t_pixel p;
        int     shape;
        int     r;
        p.blue       = 8'($urandom_range(0, 255));
        p.green      = 8'($urandom_range(0, 255));
        p.red        = 8'($urandom_range(0, 255));
        p.hue        = 8'($urandom_range(0, 179));
        p.saturation = 8'($urandom_range(0, 255));
        p.brightness = 8'($urandom_range(0, 255));
        shape = $urandom_range(0, 9);
        if (shape < 3) begin
            if ($urandom_range(0, 3) == 0) p.hue = 8'($urandom_range(0, 255));
            return p;
        end
        if (shape < 7) begin
            p.red   = 8'($urandom_range(c.red_low, 255));
            p.green = 8'($urandom_range(c.green_low, p.red));
            p.blue  = 8'($urandom_range(c.blue_low, p.green));
        end else begin
            p.blue  = 8'($urandom_range(BLUE_HIGH - 10, 250));
            r       = $urandom_range(p.blue, 255);
            p.red   = 8'(r);
            p.green = 8'($urandom_range(clamp8(r - c.color_gap - 3),
                                        clamp8(r + c.color_gap + 3)));
        end
        case ($urandom_range(0, 2))
            0:       p.hue = 8'($urandom_range(0, c.hue_high));
            1:       p.hue = 8'($urandom_range(150, 179));
            default: p.hue = 8'(clamp8(c.hue_high + $urandom_range(0, 4) - 2));
        endcase
        if ($urandom_range(0, 3) != 0)
            p.saturation = 8'($urandom_range(c.sat_low, c.sat_high));
        else
            p.saturation = $urandom_range(0, 1) ? 8'(clamp8(c.sat_low - 1))
                                                : 8'(clamp8(c.sat_high + 1));
        if ($urandom_range(0, 3) != 0)
            p.brightness = 8'($urandom_range(c.val_low, 255));
        else
            p.brightness = 8'(clamp8(c.val_low - $urandom_range(0, 2)));
        return p;
    endfunction

    // called right after the clock rises; returns once the classifier has taken the request
    task automatic send_pixel(input t_pixel p);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_drv  <= p;
        in_valid <= 1'b1;
        @(posedge i_clk iff !in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk iff flags_due == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_thresholds(input t_cfg c);
        put_reg(REG_RED_LOW,   c.red_low);
        put_reg(REG_GREEN_LOW, c.green_low);
        put_reg(REG_BLUE_LOW,  c.blue_low);
        put_reg(REG_COLOR_GAP, c.color_gap);
        put_reg(REG_HUE_HIGH,  c.hue_high);
        put_reg(REG_SAT_LOW,   c.sat_low);
        put_reg(REG_SAT_HIGH,  c.sat_high);
        put_reg(REG_VAL_LOW,   c.val_low);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        t_pixel edge_pixels [$];
        t_cfg   phase_cfg [NUM_PHASES];
        int     lo;

        edge_pixels = '{
            make_pixel(0, 0, 0, 0, 0, 0),
            make_pixel(255, 255, 255, 255, 255, 255),
            make_pixel(90, 120, 200, 10, 100, 200),
            make_pixel(180, 230, 240, 10, 100, 240),
            make_pixel(171, 211, 221, 10, 100, 230),
            make_pixel(171, 211, 220, 10, 100, 230),
            make_pixel(90, 120, 200, 180, 100, 200),
            make_pixel(90, 120, 200, 255, 100, 200),
            make_pixel(90, 120, 200, 155, 100, 200),
            make_pixel(90, 120, 200, 156, 100, 200),
            make_pixel(90, 120, 200, 19, 100, 200),
            make_pixel(90, 120, 200, 20, 100, 200),
            make_pixel(90, 120, 200, 10, 20, 200),
            make_pixel(90, 120, 200, 10, 19, 200),
            make_pixel(90, 120, 200, 10, 154, 200),
            make_pixel(90, 120, 200, 10, 155, 200),
            make_pixel(90, 120, 200, 10, 100, 50),
            make_pixel(90, 120, 200, 10, 100, 49),
            make_pixel(90, 120, 200, 10, 100, 255),
            make_pixel(30, 85, 100, 10, 100, 200),
            make_pixel(30, 100, 100, 10, 100, 200),
            make_pixel(21, 41, 61, 10, 100, 200),
            make_pixel(21, 41, 60, 10, 100, 200),
            make_pixel(120, 100, 200, 10, 100, 200),
            make_pixel(210, 100, 200, 10, 100, 200)
        };

        phase_cfg[0] = '0;
        phase_cfg[1] = '1;
        phase_cfg[2] = CFG_RESET;
        phase_cfg[2].sat_low  = 8'd200;   // crossed limits: nothing can be skin
        phase_cfg[2].sat_high = 8'd100;
        phase_cfg[3] = CFG_RESET;
        phase_cfg[3].hue_high = 8'd200;
        phase_cfg[4] = CFG_RESET;
        for (int i = 5; i < NUM_PHASES; i++) begin
            lo = $urandom_range(0, 100);
            phase_cfg[i].red_low   = 8'($urandom_range(0, 200));
            phase_cfg[i].green_low = 8'($urandom_range(0, 150));
            phase_cfg[i].blue_low  = 8'($urandom_range(0, 120));
            phase_cfg[i].color_gap = 8'($urandom_range(0, 60));
            phase_cfg[i].hue_high  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                                 : 8'($urandom_range(0, 180));
            phase_cfg[i].sat_low   = 8'(lo);
            phase_cfg[i].sat_high  = 8'($urandom_range(lo, 255));
            phase_cfg[i].val_low   = 8'($urandom_range(0, 150));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_pixels[i])
            send_pixel(edge_pixels[i]);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_thresholds(phase_cfg[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 48 == 0) begin
                    send_burst = ($urandom_range(0, 3) == 0);
                    recv_burst = ($urandom_range(0, 3) == 0);
                end
                // long sink hold while requests keep coming, to back up the pipe
                if ((ph == 4 || ph == 7) && k == 20) begin
                    send_burst    = 1'b1;
                    long_hold_req = 1'b1;
                end
                send_pixel(random_pixel(phase_cfg[ph]));
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ skin_color_pixel_classifier.f @@
sv/scc_pkg.sv
sv/scc_cfg_regs.sv
sv/scc_classify.sv
sv/skin_color_pixel_classifier.sv
test/skin_flag_monitor.sv
test/tb.sv
